// File: hdl/slfr_pkg.sv
// Package for the sync/length frame receiver.
// Holds shared types, configuration register codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slfr_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_WRITES = 2'd3;
    localparam int unsigned CFG_DATA_W = 8;

    // Reset values of the configuration registers.
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd90;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd165;
    localparam logic [7:0] WRITE_CODE_RST  = 8'd130;
    localparam logic       DROP_WRITES_RST = 1'b0;

    // Fixed positions inside a frame, counted after the sync pair.
    localparam logic [7:0] LENGTH_POS = 8'd0;
    localparam logic [7:0] CMD_POS    = 8'd1;

    // Configuration seen by the front end.
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] write_code;
        logic       drop_writes;
    } t_cfg;

    // One write into the frame buffers.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] pos;
        logic [7:0] data;
    } t_store_wr;

    // A completed frame waiting to be sent: its buffer bank and its length.
    typedef struct packed {
        logic       bank;
        logic [7:0] len;
    } t_frame_desc;

endpackage

`default_nettype wire

// File: hdl/slfr_in_if.sv
// Input channel of the frame receiver: one received serial byte per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface slfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/slfr_out_if.sv
// Output channel of the frame receiver: one frame byte per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface slfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       last_byte;

    modport source (output valid, output frame_byte, output byte_index,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/slfr_front.sv
// Front end of the frame receiver: sync hunt, length tracking, timeout,
// write filter and buffer writes. Depends on slfr_pkg and slfr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module slfr_front
    import slfr_pkg::*;
#(
    parameter int unsigned TIMEOUT_BYTES = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    slfr_in_if.sink     i_rx,
    input  t_cfg        i_cfg,
    input  wire         i_q_full,
    output t_store_wr   o_wr,
    output logic        o_push,
    output t_frame_desc o_desc
);

    localparam int unsigned CW = $clog2(TIMEOUT_BYTES + 2);

    logic          r_in_frame, n_in_frame;
    logic [7:0]    r_prev, n_prev;
    logic [7:0]    r_len, n_len;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_cmd, n_cmd;
    logic          r_bank, n_bank;

    logic          accept;
    logic [7:0]    b;
    logic [CW-1:0] count_inc;
    logic [7:0]    count_ext;
    logic [7:0]    cmd_now;
    logic          drop;

    // A frame byte waits while both buffers hold frames not yet sent.
    assign i_rx.ready = !r_in_frame || !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign count_inc  = r_count + 1'b1;
    assign count_ext  = 8'(r_count);

    // The command byte is this byte when it lands at the command position.
    assign cmd_now = (count_ext == CMD_POS) ? b : r_cmd;
    assign drop    = i_cfg.drop_writes && (cmd_now == i_cfg.write_code);

    // Next-state logic for one accepted byte.
    always_comb begin
        n_in_frame = r_in_frame;
        n_prev     = r_prev;
        n_len      = r_len;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_bank     = r_bank;
        o_wr.en    = 1'b0;
        o_wr.bank  = r_bank;
        o_wr.pos   = count_ext;
        o_wr.data  = b;
        o_push     = 1'b0;
        o_desc.bank = r_bank;
        o_desc.len  = r_len;
        if (accept) begin
            if (!r_in_frame) begin
                if (b == i_cfg.sync_second && r_prev == i_cfg.sync_first) begin
                    n_in_frame = 1'b1;
                    n_count    = '0;
                end else begin
                    n_prev = b;
                end
            end else begin
                o_wr.en = 1'b1;
                if (count_ext == CMD_POS) begin
                    n_cmd = b;
                end
                if (count_ext == LENGTH_POS) begin
                    n_len   = b;
                    n_count = count_inc;
                end else if (count_ext == r_len) begin
                    // Frame complete: hand it to the back end unless filtered.
                    n_in_frame = 1'b0;
                    n_count    = '0;
                    if (!drop) begin
                        o_push = 1'b1;
                        n_bank = !r_bank;
                    end
                end else if (count_inc > CW'(TIMEOUT_BYTES)) begin
                    n_in_frame = 1'b0;
                    n_count    = '0;
                end else begin
                    n_count = count_inc;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_prev     <= '0;
            r_len      <= '0;
            r_count    <= '0;
            r_cmd      <= '0;
            r_bank     <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_prev     <= n_prev;
            r_len      <= n_len;
            r_count    <= n_count;
            r_cmd      <= n_cmd;
            r_bank     <= n_bank;
        end
    end

endmodule

`default_nettype wire

// File: hdl/slfr_queue.sv
// Two-entry queue of completed frame descriptors between front and back end.
// Depends on slfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slfr_queue
    import slfr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  t_frame_desc i_desc,
    output logic        o_full,
    input  wire         i_pop,
    output logic        o_valid,
    output t_frame_desc o_desc
);

    t_frame_desc r_ent [2];
    logic [1:0]  r_count;
    logic        r_wr_ptr;
    logic        r_rd_ptr;

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_ent[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/slfr_back.sv
// Back end of the frame receiver: two frame buffers and the sender that
// streams a completed frame out. Depends on slfr_pkg and slfr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module slfr_back
    import slfr_pkg::*;
#(
    parameter int unsigned TIMEOUT_BYTES = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_store_wr   i_wr,
    input  wire         i_q_valid,
    input  t_frame_desc i_desc,
    output logic        o_pop,
    slfr_out_if.source  o_frame
);

    localparam int unsigned IW    = $clog2(TIMEOUT_BYTES + 1);
    localparam int unsigned DEPTH = 2 ** (IW + 1);

    // Two banks of frame bytes, one frame each.
    logic [7:0]    r_mem [DEPTH];

    logic          r_active;
    logic          r_bank;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_len;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [4:0]    r_out_index;
    logic          r_out_last;

    logic          start;
    logic          load;
    logic          at_last;

    // The head descriptor stays queued until its last byte has been read, so
    // its bank cannot be refilled by the front end while it is being sent.
    assign start   = !r_active && i_q_valid;
    assign load    = r_active && (!r_out_valid || o_frame.ready);
    assign at_last = (8'(r_idx) == r_len);
    assign o_pop   = load && at_last;

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.byte_index = r_out_index;
    assign o_frame.last_byte  = r_out_last;

    // Buffer write from the front end.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.pos[IW-1:0]}] <= i_wr.data;
        end
    end

    // Registered read straight into the output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte  <= r_mem[{r_bank, r_idx}];
            r_out_index <= 5'(r_idx);
            r_out_last  <= at_last;
        end
    end

    // Frame sequencing and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_bank      <= 1'b0;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) begin
                r_active <= 1'b1;
                r_bank   <= i_desc.bank;
                r_len    <= i_desc.len;
                r_idx    <= '0;
            end else if (load) begin
                if (at_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/sync_length_frame_receiver_unit.sv
// Top level of the sync/length frame receiver: configuration registers and
// the front end, descriptor queue and back end. Depends on slfr_pkg and
// the slfr modules and interfaces.
//
//  Port      | Dir | Carries
//  ----------+-----+------------------------------------------------
//  i_rx      | in  | rx_byte, one received serial byte per transfer
//  o_frame   | out | frame_byte, byte_index, last_byte per transfer
//  i_cfg_*   | in  | register write: enable, index, data
//
// Received bytes are taken one per cycle; the front end only holds off a
// frame byte while both frame buffers hold frames still being sent.
// A frame of length L leaves as L+1 transfers, one per cycle while o_frame
// is ready; its first byte follows a descriptor fetch, then a buffer read
// into the output register, and the next frame is fetched only after the
// last byte of the one before has been read.
// Reset is synchronous and active low; the frame buffers need no clearing.
// The output register lets the back end stall without stopping the front.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_receiver_unit
    import slfr_pkg::*;
#(
    parameter int unsigned TIMEOUT_BYTES = 20
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    slfr_in_if.sink              i_rx,
    slfr_out_if.source           o_frame,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    t_store_wr   wr;
    logic        push;
    t_frame_desc push_desc;
    logic        q_full;
    logic        q_valid;
    logic        pop;
    t_frame_desc pop_desc;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.write_code  <= WRITE_CODE_RST;
            r_cfg.drop_writes <= DROP_WRITES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                CFG_WRITE_CODE:  r_cfg.write_code  <= i_cfg_data;
                CFG_DROP_WRITES: r_cfg.drop_writes <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front end: sync hunt and frame capture.
    slfr_front #(
        .TIMEOUT_BYTES(TIMEOUT_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (r_cfg),
        .i_q_full(q_full),
        .o_wr    (wr),
        .o_push  (push),
        .o_desc  (push_desc)
    );

    // Queue of completed frames.
    slfr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_desc (push_desc),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_desc (pop_desc)
    );

    // Back end: frame buffers and byte sender.
    slfr_back #(
        .TIMEOUT_BYTES(TIMEOUT_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_q_valid(q_valid),
        .i_desc   (pop_desc),
        .o_pop    (pop),
        .o_frame  (o_frame)
    );

endmodule

`default_nettype wire

// File: tb/sv/slfr_tb_pkg.sv
// Scoreboard for the sync/length frame receiver testbench: a bit-exact
// predictor of the receiver and a queue of the frame bytes it expects.
// Depends on slfr_pkg.
`timescale 1ns / 1ps

package slfr_tb_pkg;
    import slfr_pkg::*;

    localparam int unsigned TIMEOUT_BYTES = 20;
    localparam int unsigned STORE_DEPTH   = TIMEOUT_BYTES + 1;

    // One frame byte as it leaves the receiver.
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] index;
        logic       last;
    } frame_beat_t;

    class frame_scoreboard;
        // Register copies.
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] write_code;
        logic       drop_writes;

        // Receiver state.
        logic       in_frame;
        logic [7:0] prev_byte;
        logic [7:0] frame_len;
        logic [4:0] byte_count;
        logic [4:0] tick_count;
        logic [7:0] frame_buf [STORE_DEPTH];

        frame_beat_t expected_frame_bytes [$];

        int unsigned errors;
        int unsigned beats_checked;
        int unsigned frames_sent;
        int unsigned frames_dropped;
        int unsigned frames_aborted;

        function new();
            sync_first     = SYNC_FIRST_RST;
            sync_second    = SYNC_SECOND_RST;
            write_code     = WRITE_CODE_RST;
            drop_writes    = DROP_WRITES_RST;
            in_frame       = 1'b0;
            prev_byte      = '0;
            frame_len      = '0;
            byte_count     = '0;
            tick_count     = '0;
            errors         = 0;
            beats_checked  = 0;
            frames_sent    = 0;
            frames_dropped = 0;
            frames_aborted = 0;
            foreach (frame_buf[k]) frame_buf[k] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SYNC_FIRST:  sync_first  = value;
                CFG_SYNC_SECOND: sync_second = value;
                CFG_WRITE_CODE:  write_code  = value;
                CFG_DROP_WRITES: drop_writes = value[0];
                default: ;
            endcase
        endfunction

        // Advance the receiver by one accepted byte and queue any frame it completes.
        function void take_rx_byte(logic [7:0] b);
            int i;
            frame_beat_t beat;
            if (!in_frame) begin
                // The previous byte is left alone on a sync hit.
                if (b == sync_second && prev_byte == sync_first) begin
                    in_frame   = 1'b1;
                    frame_len  = 8'd6;
                    byte_count = '0;
                    tick_count = '0;
                end else begin
                    prev_byte = b;
                end
                return;
            end

            if (int'(byte_count) < STORE_DEPTH) frame_buf[byte_count] = b;

            if (8'(byte_count) == LENGTH_POS) begin
                frame_len = b;
            end else if (8'(byte_count) == frame_len) begin
                byte_count = '0;
                in_frame   = 1'b0;
                if (drop_writes && frame_buf[CMD_POS] == write_code) begin
                    frames_dropped++;
                    return;
                end
                frames_sent++;
                for (i = 0; i <= int'(frame_len); i++) begin
                    beat.data  = frame_buf[i];
                    beat.index = 5'(i);
                    beat.last  = (i == int'(frame_len));
                    expected_frame_bytes.push_back(beat);
                end
                return;
            end

            byte_count = byte_count + 5'd1;
            tick_count = tick_count + 5'd1;
            // Too many bytes since sync: the frame is abandoned.
            if (int'(tick_count) > TIMEOUT_BYTES) begin
                byte_count = '0;
                in_frame   = 1'b0;
                frames_aborted++;
            end
        endfunction

        // Compare one transferred frame byte against the oldest expectation.
        function void check_frame_byte(logic [7:0] data, logic [4:0] index, logic last);
            frame_beat_t want;
            if (expected_frame_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame byte: byte=%02h index=%0d last=%0b",
                         $time, data, index, last);
                return;
            end
            want = expected_frame_bytes.pop_front();
            beats_checked++;
            if (want.data !== data || want.index !== index || want.last !== last) begin
                errors++;
                $display("%0t: frame byte mismatch: expected byte=%02h index=%0d last=%0b, actual byte=%02h index=%0d last=%0b",
                         $time, want.data, want.index, want.last, data, index, last);
            end
        endfunction

        function int outstanding();
            return expected_frame_bytes.size();
        endfunction
    endclass

endpackage

// File: tb/sv/sync_length_frame_receiver_unit_tb.sv
// Testbench top for the sync/length frame receiver: drives sync pairs, frames,
// noise and broken sequences under four register settings with random stalls.
// Depends on slfr_pkg, slfr_in_if, slfr_out_if and slfr_tb_pkg.
`timescale 1ns / 1ps

module sync_length_frame_receiver_unit_tb;
    import slfr_pkg::*;
    import slfr_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    slfr_in_if  rx_ch ();
    slfr_out_if frame_ch ();

    sync_length_frame_receiver_unit #(
        .TIMEOUT_BYTES(TIMEOUT_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_frame    (frame_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    frame_scoreboard sb = new();

    bit          steady;
    int unsigned rx_count;
    int unsigned cycle_count;
    logic [7:0]  cur_sync_first;
    logic [7:0]  cur_sync_second;
    logic [7:0]  cur_write_code;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones; none while steady.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Output side: ready toggles in runs, with stall gaps.
    initial begin
        int g;
        frame_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            frame_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            g = pick_gap();
            if (g != 0) begin
                frame_ch.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
    end

    // Output monitor: every completed transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
            sb.check_frame_byte(frame_ch.frame_byte, frame_ch.byte_index, frame_ch.last_byte);
    end

    // Write all four registers, one per cycle. Called only while idle.
    task automatic write_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] wc, input logic dw);
        logic [CFG_IDX_W-1:0]  idxs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int k;
        idxs = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_WRITE_CODE, CFG_DROP_WRITES};
        vals = '{sf, ss, wc, 8'(dw)};
        for (k = 0; k < 4; k++) begin
            @(negedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[k];
            cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idxs[k], vals[k]);
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_sync_first  = sf;
        cur_sync_second = ss;
        cur_write_code  = wc;
    endtask

    // Offer one byte and hold it until the transfer; called at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int g;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (rx_ch.ready !== 1'b1) @(posedge i_clk);
        sb.take_rx_byte(b);
        rx_count++;
        @(negedge i_clk);
        g = pick_gap();
        if (g != 0) begin
            rx_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // Sync pair, length byte and the rest of the frame. Lengths that never
    // complete get just enough bytes to run into the byte limit.
    task automatic send_frame(input logic [7:0] len, input logic is_write);
        int n;
        int k;
        logic [7:0] b;
        n = (len >= 1 && len <= TIMEOUT_BYTES) ? int'(len) : TIMEOUT_BYTES;
        send_byte(cur_sync_first);
        send_byte(cur_sync_second);
        send_byte(len);
        for (k = 1; k <= n; k++) begin
            b = 8'($urandom);
            if (k == int'(CMD_POS) && is_write) b = cur_write_code;
            send_byte(b);
        end
    endtask

    // Stop sending and wait until every expected frame byte has been seen,
    // then let a dropped frame work its way out as well.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly well-formed frames with random content, plus noise and broken ones.
    task automatic random_traffic(input int unsigned nbytes);
        int unsigned start;
        int r;
        start = rx_count;
        while (rx_count - start < nbytes) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                if ($urandom_range(0, 3) == 0)
                    send_frame(8'($urandom_range(7, TIMEOUT_BYTES)), 1'($urandom));
                else
                    send_frame(8'($urandom_range(1, 6)), 1'($urandom));
            end else if (r < 75) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (r < 83) begin
                if ($urandom_range(0, 1) == 0)
                    send_frame(8'd0, 1'b0);
                else
                    send_frame(8'($urandom_range(TIMEOUT_BYTES + 1, 255)), 1'b0);
            end else if (r < 93) begin
                // Frame cut short; the next sync pair lands inside it.
                send_byte(cur_sync_first);
                send_byte(cur_sync_second);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            end else begin
                send_byte(cur_sync_first);
                send_byte(8'($urandom));
            end
        end
    endtask

    // Main sequence.
    initial begin
        steady        = 1'b0;
        rx_count      = 0;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_SYNC_FIRST;
        cfg_data      = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        cur_sync_first  = SYNC_FIRST_RST;
        cur_sync_second = SYNC_SECOND_RST;
        cur_write_code  = WRITE_CODE_RST;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values, filter off.
        write_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, WRITE_CODE_RST, DROP_WRITES_RST);
        // Shortest frame, all-ones payload.
        send_byte(8'h00);
        send_byte(cur_sync_first);
        send_byte(cur_sync_second);
        send_byte(8'd1);
        send_byte(8'hFF);
        // The previous byte still holds the first sync byte, so the second
        // sync byte alone opens the next frame. A write frame passes here.
        send_byte(cur_sync_second);
        send_byte(8'd2);
        send_byte(cur_write_code);
        send_byte(8'h00);
        // First sync byte repeated before the second.
        send_byte(cur_sync_first);
        send_byte(cur_sync_first);
        send_byte(cur_sync_second);
        send_byte(8'd3);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h7F);
        settle();

        // Filter on: a write frame vanishes, the next one passes.
        write_regs(8'd90, 8'd165, 8'd130, 1'b1);
        send_frame(8'd2, 1'b1);
        send_byte(cur_sync_second);
        send_byte(8'd1);
        send_byte(8'h80);
        // Longest frame and a zero length.
        send_frame(8'(TIMEOUT_BYTES), 1'b0);
        send_frame(8'd0, 1'b0);
        random_traffic(8);
        settle();

        // Extreme sync values, all-ones write code, filter on.
        write_regs(8'h00, 8'hFF, 8'hFF, 1'b1);
        random_traffic(8);
        // Hold off the sender until the back end has caught up.
        settle();
        random_traffic(4);
        settle();

        // The opposite extremes, filter off; first a stretch without stalls.
        write_regs(8'hFF, 8'h00, 8'h00, 1'b0);
        steady = 1'b1;
        random_traffic(5);
        steady = 1'b0;
        random_traffic(5);
        settle();

        if (sb.outstanding() != 0) begin
            sb.errors += sb.outstanding();
            $display("%0t: %0d expected frame bytes never arrived", $time, sb.outstanding());
        end
        $display("Sent %0d bytes over four register settings: %0d frames out, %0d dropped,",
                 rx_count, sb.frames_sent, sb.frames_dropped);
        $display("%0d aborted by the byte limit, %0d frame bytes checked.",
                 sb.frames_aborted, sb.beats_checked);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
